// ===== hw/rtl/pcd_pkg.sv =====
`timescale 1ns / 1ps

package pcd_pkg;

  // Region codes as they appear on the output
  localparam logic [2:0] REGION_SIG  = 3'd0;
  localparam logic [2:0] REGION_LEN  = 3'd1;
  localparam logic [2:0] REGION_TYPE = 3'd2;
  localparam logic [2:0] REGION_DATA = 3'd3;
  localparam logic [2:0] REGION_CRC  = 3'd4;

  localparam logic [2:0] SIG_LAST   = 3'd7;
  localparam logic [2:0] FIELD_LAST = 3'd3;

  localparam logic [7:0] PNG_SIG [0:7] = '{
    8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
  };

  typedef enum logic [4:0] {
    PH_SIG  = 5'b00001,
    PH_LEN  = 5'b00010,
    PH_TYPE = 5'b00100,
    PH_DATA = 5'b01000,
    PH_CRC  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        truncated;
    logic        signature_bad;
    logic [31:0] stored_crc;
    logic [31:0] chunk_type;
    logic [31:0] chunk_length;
    logic        chunk_done;
    logic [2:0]  region;
    logic [7:0]  data_out;
  } result_t;

endpackage

// ===== hw/rtl/png_chunk_deframer.sv =====
`timescale 1ns / 1ps

// PNG chunk deframer. Takes a PNG file one byte per transaction on s_axis
// (tlast marks the file's last byte) and returns every byte unchanged on
// m_axis, tagged with its region (signature, length, type, data, crc) and
// with the chunk's length, type and CRC shift registers. m_axis_tlast marks
// the last CRC byte of a chunk; signature_bad is sticky for the file;
// truncated marks a last byte that closes neither chunk nor signature. After
// a last byte the parser starts over on a new file. Throughput is one byte
// per clock; each byte passes one input register and one result register, with
// the parse logic between them. Backpressure on m_axis stalls both.
module png_chunk_deframer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_in[7:0]
  input  logic         s_axis_tlast,   // end_of_stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // data_out[7:0], chunk_length[39:8],
                                       // chunk_type[71:40], stored_crc[103:72]
  output logic         m_axis_tlast,   // chunk_done
  output logic [4:0]   m_axis_tuser    // region[2:0], signature_bad[3],
                                       // truncated[4]
);

  localparam int ResW = $bits(pcd_pkg::result_t);

  logic            in_valid;
  logic            res_ready;
  logic [8:0]      in_data;
  pcd_pkg::result_t res;
  pcd_pkg::result_t res_q;
  logic [ResW-1:0] res_flat;
  logic [ResW-1:0] res_q_flat;

  pcd_stage #(.Width(9)) u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  ({s_axis_tlast, s_axis_tdata}),
    .out_valid(in_valid),
    .out_ready(res_ready),
    .out_data (in_data)
  );

  pcd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .advance(in_valid && res_ready),
    .byte_in(in_data[7:0]),
    .eos    (in_data[8]),
    .result (res)
  );

  assign res_flat = res;

  pcd_stage #(.Width(ResW)) u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (res_ready),
    .in_data  (res_flat),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (res_q_flat)
  );

  assign res_q = res_q_flat;

  assign m_axis_tdata = {res_q.stored_crc, res_q.chunk_type, res_q.chunk_length,
                         res_q.data_out};
  assign m_axis_tlast = res_q.chunk_done;
  assign m_axis_tuser = {res_q.truncated, res_q.signature_bad, res_q.region};

endmodule

// ===== hw/rtl/pcd_stage.sv =====
`timescale 1ns / 1ps

// One register slice with valid/ready; full rate, in_ready passes out_ready through combinationally.
module pcd_stage #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [Width-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [Width-1:0] out_data
);

  logic             valid;
  logic [Width-1:0] data;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

endmodule

// ===== hw/rtl/pcd_parser.sv =====
`timescale 1ns / 1ps

// Chunk parsing state; result is combinational from the registered byte,
// state advances when the byte moves into the result register.
module pcd_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic [7:0]      byte_in,
  input  logic            eos,
  output pcd_pkg::result_t result
);

  pcd_pkg::phase_t phase, phase_next;
  logic [2:0]  field_count, field_count_next;
  logic [31:0] length_value, length_value_next;
  logic [31:0] type_value, type_value_next;
  logic [31:0] crc_value, crc_value_next;
  logic [31:0] data_left, data_left_next;
  logic        sig_mismatch, sig_mismatch_next;
  logic        done;
  logic        boundary;
  logic [2:0]  region;
  logic [31:0] left_dec;

  always_comb begin
    phase_next        = phase;
    field_count_next  = field_count;
    length_value_next = length_value;
    type_value_next   = type_value;
    crc_value_next    = crc_value;
    data_left_next    = data_left;
    sig_mismatch_next = sig_mismatch;
    done              = 1'b0;
    boundary          = 1'b0;
    region            = pcd_pkg::REGION_LEN;
    left_dec          = (data_left != 32'd0) ? data_left - 32'd1 : data_left;

    case (phase)
      pcd_pkg::PH_SIG: begin
        region = pcd_pkg::REGION_SIG;
        if (byte_in != pcd_pkg::PNG_SIG[field_count]) begin
          sig_mismatch_next = 1'b1;
        end
        if (field_count >= pcd_pkg::SIG_LAST) begin
          field_count_next = 3'd0;
          phase_next       = pcd_pkg::PH_LEN;
          boundary         = 1'b1;
        end else begin
          field_count_next = field_count + 3'd1;
        end
      end
      pcd_pkg::PH_TYPE: begin
        region          = pcd_pkg::REGION_TYPE;
        type_value_next = {type_value[23:0], byte_in};
        if (field_count >= pcd_pkg::FIELD_LAST) begin
          field_count_next = 3'd0;
          phase_next = (data_left == 32'd0) ? pcd_pkg::PH_CRC : pcd_pkg::PH_DATA;
        end else begin
          field_count_next = field_count + 3'd1;
        end
      end
      pcd_pkg::PH_DATA: begin
        region         = pcd_pkg::REGION_DATA;
        data_left_next = left_dec;
        if (left_dec == 32'd0) begin
          field_count_next = 3'd0;
          phase_next       = pcd_pkg::PH_CRC;
        end
      end
      pcd_pkg::PH_CRC: begin
        region         = pcd_pkg::REGION_CRC;
        crc_value_next = {crc_value[23:0], byte_in};
        if (field_count >= pcd_pkg::FIELD_LAST) begin
          field_count_next = 3'd0;
          phase_next       = pcd_pkg::PH_LEN;
          done             = 1'b1;
          boundary         = 1'b1;
        end else begin
          field_count_next = field_count + 3'd1;
        end
      end
      default: begin
        // length field; an unknown phase code restarts it from the first byte
        region            = pcd_pkg::REGION_LEN;
        length_value_next = {length_value[23:0], byte_in};
        if (phase == pcd_pkg::PH_LEN && field_count >= pcd_pkg::FIELD_LAST) begin
          field_count_next = 3'd0;
          data_left_next   = length_value_next;
          phase_next       = pcd_pkg::PH_TYPE;
        end else if (phase == pcd_pkg::PH_LEN) begin
          field_count_next = field_count + 3'd1;
        end else begin
          field_count_next = 3'd1;
          phase_next       = pcd_pkg::PH_LEN;
        end
      end
    endcase
  end

  assign result.data_out      = byte_in;
  assign result.region        = region;
  assign result.chunk_done    = done;
  assign result.chunk_length  = length_value_next;
  assign result.chunk_type    = type_value_next;
  assign result.stored_crc    = crc_value_next;
  assign result.signature_bad = sig_mismatch_next;
  assign result.truncated     = eos && !boundary;

  always_ff @(posedge clk) begin
    if (rst || (advance && eos)) begin
      phase        <= pcd_pkg::PH_SIG;
      field_count  <= 3'd0;
      length_value <= 32'd0;
      type_value   <= 32'd0;
      crc_value    <= 32'd0;
      data_left    <= 32'd0;
      sig_mismatch <= 1'b0;
    end else if (advance) begin
      phase        <= phase_next;
      field_count  <= field_count_next;
      length_value <= length_value_next;
      type_value   <= type_value_next;
      crc_value    <= crc_value_next;
      data_left    <= data_left_next;
      sig_mismatch <= sig_mismatch_next;
    end
  end

endmodule

// ===== hw/rtl/pcd_checker.sv =====
`timescale 1ns / 1ps

module pcd_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic         m_axis_tlast,
  input logic [4:0]   m_axis_tuser
);

  // chunk_done only on a CRC byte
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[2:0] == pcd_pkg::REGION_CRC))
    else $error("chunk_done outside crc region");

  // a byte that closes a chunk is never flagged truncated
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tuser[4])
    else $error("truncated on completed chunk");

  // stalled transaction holds
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
       $stable(m_axis_tuser)))
    else $error("output changed while stalled");

  // nothing leaves the block right after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind png_chunk_deframer pcd_checker u_pcd_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);

// ===== dv/png_chunk_deframer_tb.sv =====
`timescale 1ns / 1ps

module png_chunk_deframer_tb;

  localparam int RANDOM_BYTES = 1100;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } file_byte_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic [4:0]   m_axis_tuser;

  png_chunk_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  file_byte_t        file_bytes_q[$];
  pcd_pkg::result_t  tagged_bytes_q[$];
  file_byte_t        feed_item;
  int                total_bytes;
  int                accepted_bytes = 0;
  int                feed_gap = 0;
  int                feed_calm = 0;
  int                sink_stall = 0;
  int                sink_calm = 0;
  int                idle_cycles = 0;
  int                errors = 0;

  // parser state mirror
  logic [2:0]  ps_region;
  logic [2:0]  ps_count;
  logic [31:0] ps_length;
  logic [31:0] ps_type;
  logic [31:0] ps_crc;
  logic [31:0] ps_left;
  logic        ps_sig_bad;

  task automatic restart_parser();
    ps_region  = pcd_pkg::REGION_SIG;
    ps_count   = '0;
    ps_length  = '0;
    ps_type    = '0;
    ps_crc     = '0;
    ps_left    = '0;
    ps_sig_bad = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eos,
                            output pcd_pkg::result_t r);
    logic [2:0] region_now;
    logic       done;
    logic       boundary;
    region_now = ps_region;
    done       = 1'b0;
    boundary   = 1'b0;
    case (region_now)
      pcd_pkg::REGION_SIG: begin
        if (b != pcd_pkg::PNG_SIG[ps_count]) ps_sig_bad = 1'b1;
        if (ps_count == pcd_pkg::SIG_LAST) begin
          ps_count  = '0;
          ps_region = pcd_pkg::REGION_LEN;
          boundary  = 1'b1;
        end else begin
          ps_count++;
        end
      end
      pcd_pkg::REGION_LEN: begin
        ps_length = {ps_length[23:0], b};
        if (ps_count == pcd_pkg::FIELD_LAST) begin
          ps_count  = '0;
          ps_left   = ps_length;
          ps_region = pcd_pkg::REGION_TYPE;
        end else begin
          ps_count++;
        end
      end
      pcd_pkg::REGION_TYPE: begin
        ps_type = {ps_type[23:0], b};
        if (ps_count == pcd_pkg::FIELD_LAST) begin
          ps_count  = '0;
          ps_region = (ps_left == 0) ? pcd_pkg::REGION_CRC : pcd_pkg::REGION_DATA;
        end else begin
          ps_count++;
        end
      end
      pcd_pkg::REGION_DATA: begin
        if (ps_left != 0) ps_left--;
        if (ps_left == 0) begin
          ps_count  = '0;
          ps_region = pcd_pkg::REGION_CRC;
        end
      end
      default: begin
        ps_crc = {ps_crc[23:0], b};
        if (ps_count == pcd_pkg::FIELD_LAST) begin
          ps_count  = '0;
          ps_region = pcd_pkg::REGION_LEN;
          done      = 1'b1;
          boundary  = 1'b1;
        end else begin
          ps_count++;
        end
      end
    endcase
    r.data_out      = b;
    r.region        = region_now;
    r.chunk_done    = done;
    r.chunk_length  = ps_length;
    r.chunk_type    = ps_type;
    r.stored_crc    = ps_crc;
    r.signature_bad = ps_sig_bad;
    r.truncated     = eos && !boundary;
    if (eos) restart_parser();
  endtask

  // --- stimulus construction ---
  task automatic append_word(ref logic [7:0] q[$], input logic [31:0] w);
    for (int i = 3; i >= 0; i--) q.push_back(w[8*i +: 8]);
  endtask

  task automatic queue_file(ref logic [7:0] q[$]);
    for (int i = 0; i < q.size(); i++) file_bytes_q.push_back({q[i], i == q.size() - 1});
  endtask

  task automatic gen_file();
    logic [7:0] fb[$];
    int         mode;
    int         n_chunks;
    int         len;
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      // line noise
      len = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) fb.push_back(8'($urandom));
    end else begin
      for (int i = 0; i < 8; i++)
        fb.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : pcd_pkg::PNG_SIG[i]);
      n_chunks = $urandom_range(0, 4);
      for (int c = 0; c < n_chunks; c++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: len = 0;
          9:       len = $urandom_range(17, 64);
          default: len = $urandom_range(1, 16);
        endcase
        append_word(fb, len);
        append_word(fb, $urandom);
        for (int i = 0; i < len; i++) fb.push_back(8'($urandom));
        append_word(fb, $urandom);
      end
      if (mode == 1) begin
        // huge declared length, file cut short before the data ends
        append_word(fb, $urandom | 32'h100);
        append_word(fb, $urandom);
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) fb.push_back(8'($urandom));
      end else if (mode <= 4) begin
        fb = fb[0:$urandom_range(0, fb.size() - 1)];
      end
    end
    queue_file(fb);
  endtask

  task automatic build_stimulus();
    logic [7:0] fb[$];
    int         directed;
    // two wrong signature bytes, file ends inside the signature
    fb = '{8'h00, 8'hFF};
    queue_file(fb);
    // good signature, zero-length chunk, then all-ones length cut short in data
    fb.delete();
    for (int i = 0; i < 8; i++) fb.push_back(pcd_pkg::PNG_SIG[i]);
    append_word(fb, 32'h0000_0000);
    append_word(fb, 32'h4945_4E44);
    append_word(fb, 32'hAE42_6082);
    append_word(fb, 32'hFFFF_FFFF);
    append_word(fb, 32'h7445_5874);
    fb.push_back(8'h5A);
    queue_file(fb);
    directed = file_bytes_q.size();
    while (file_bytes_q.size() - directed < RANDOM_BYTES) gen_file();
    total_bytes = file_bytes_q.size();
  endtask

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // --- driver ---
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pcd_pkg::result_t r;
        parse_byte(s_axis_tdata, s_axis_tlast, r);
        tagged_bytes_q.push_back(r);
        accepted_bytes++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (feed_gap > 0) begin
          feed_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (file_bytes_q.size() > 0) begin
          feed_item = file_bytes_q.pop_front();
          s_axis_tdata  <= feed_item.data;
          s_axis_tlast  <= feed_item.last;
          s_axis_tvalid <= 1'b1;
          feed_gap = pick_gap(feed_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --- monitor ---
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (tagged_bytes_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual tdata %0h tuser %0h",
                   $time, m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          pcd_pkg::result_t want;
          want = tagged_bytes_q.pop_front();
          check_field("data_out", 32'(want.data_out), 32'(m_axis_tdata[7:0]));
          check_field("chunk_length", want.chunk_length, m_axis_tdata[39:8]);
          check_field("chunk_type", want.chunk_type, m_axis_tdata[71:40]);
          check_field("stored_crc", want.stored_crc, m_axis_tdata[103:72]);
          check_field("region", 32'(want.region), 32'(m_axis_tuser[2:0]));
          check_field("chunk_done", 32'(want.chunk_done), 32'(m_axis_tlast));
          check_field("signature_bad", 32'(want.signature_bad), 32'(m_axis_tuser[3]));
          check_field("truncated", 32'(want.truncated), 32'(m_axis_tuser[4]));
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sink_stall = pick_gap(sink_calm);
      end
    end
  end

  // --- watchdog ---
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    restart_parser();
    build_stimulus();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (accepted_bytes < total_bytes) @(posedge clk);
    while (tagged_bytes_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tagged_bytes_q.size() > 0) begin
      $display("%0t: %0d results never arrived", $time, tagged_bytes_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
